// ===== rtl/fsc_pkg.sv =====
// fsc_pkg: shared types, codes and constant tables of the frustum sphere cull block
// depends on nothing; used by fsc_ctrl, fsc_dp and frustum_sphere_cull_top
package fsc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int NUM_CORNERS = 8;
  localparam int NORM_SHIFT = 30;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEST = 1'b1;
  localparam logic [2:0] LAST_CORNER = 3'd7;
  localparam logic [2:0] LAST_PLANE = 3'd5;

  typedef struct packed {
    logic              action;
    logic [2:0]        corner_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] margin;
  } in_item_t;

  typedef struct packed {
    logic reply_kind;
    logic inside_res;
  } out_item_t;

  typedef enum logic [1:0] {CRD_NONE, CRD_P, CRD_E0, CRD_E1} crd_t;
  typedef enum logic [1:0] {NRM_NONE, NRM_LOAD, NRM_COUNT, NRM_SCALE} nrm_t;
  typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;
  typedef enum logic [1:0] {SQ_NONE, SQ_LOAD, SQ_STEP} sq_t;
  typedef enum logic [1:0] {DV_NONE, DV_LOAD, DV_STEP, DV_STORE} dv_t;
  typedef enum logic [3:0] {
    OPD_V0, OPD_V1, OPD_V2, OPD_V3, OPD_V4, OPD_V5,
    OPD_N0, OPD_N1, OPD_N2, OPD_PX, OPD_PY, OPD_PZ,
    OPD_QA, OPD_QB, OPD_QC
  } opnd_t;

  typedef struct packed {
    logic       accept;
    crd_t       crd;
    logic [2:0] corner_sel;
    nrm_t       nrm;
    logic       mul_en;
    opnd_t      opa;
    opnd_t      opb;
    acc_op_t    acc_op;
    logic       cr_wr;
    logic [1:0] cr_idx;
    logic       v_copy;
    sq_t        sq;
    dv_t        dv;
    logic [1:0] div_idx;
    logic       plane_wr;
    logic [2:0] plane_idx;
    logic       tst_check;
  } cmd_t;

  typedef struct packed {
    logic or_zero;
    logic in_frustum;
  } sts_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    logic [63:0] m;
    m = x[63] ? 64'(-x) : 64'(x);
    return m;
  endfunction

  // corner triple (p1, p2, p3) of each plane
  function automatic logic [2:0] tri_corner(input logic [2:0] plane, input logic [1:0] pos);
    logic [8:0] t;
    case (plane)
      3'd0:    t = {3'd1, 3'd5, 3'd6};
      3'd1:    t = {3'd4, 3'd0, 3'd3};
      3'd2:    t = {3'd4, 3'd5, 3'd1};
      3'd3:    t = {3'd3, 3'd2, 3'd6};
      3'd4:    t = {3'd5, 3'd4, 3'd7};
      3'd5:    t = {3'd0, 3'd1, 3'd2};
      default: t = '0;
    endcase
    case (pos)
      2'd0:    return t[8:6];
      2'd1:    return t[5:3];
      default: return t[2:0];
    endcase
  endfunction

endpackage

// ===== rtl/frustum_sphere_cull_top.sv =====
// Frustum sphere cull: one transaction at a time on start/busy, one reply strobe per
// transaction, and the receiver cannot stall. A load of corners 0 to 6 replies in the
// cycle after it is accepted. A test runs all six planes through the single shared 32x32
// multiply-accumulate, one plane after another. A load of corner 7 rebuilds all six planes
// through the same unit plus a bit-serial normalize, square root and divider.
// busy is high while a transaction runs.
// depends on fsc_pkg, fsc_ctrl and fsc_dp
module frustum_sphere_cull_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fsc_pkg::in_item_t   in_data,
  output logic                out_valid,
  output fsc_pkg::out_item_t  out_data
);

  fsc_pkg::cmd_t cmd;
  fsc_pkg::sts_t sts;
  logic          out_kind;

  fsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_data),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid),
    .out_kind  (out_kind)
  );

  fsc_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_item (in_data),
    .sts     (sts)
  );

  // load replies always report outside
  assign out_data.reply_kind = out_kind;
  assign out_data.inside_res = out_kind & sts.in_frustum;

endmodule

// ===== rtl/fsc_dp.sv =====
// fsc_dp: datapath with corner and plane stores, shared multiply-accumulate,
// normalize unit, square root and divider; depends on fsc_pkg
module fsc_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  fsc_pkg::cmd_t    cmd,
  input  fsc_pkg::in_item_t in_item,
  output fsc_pkg::sts_t    sts
);

  logic signed [31:0] cx_r [fsc_pkg::NUM_CORNERS];
  logic signed [31:0] cy_r [fsc_pkg::NUM_CORNERS];
  logic signed [31:0] cz_r [fsc_pkg::NUM_CORNERS];
  logic signed [31:0] na_r [fsc_pkg::NUM_PLANES];
  logic signed [31:0] nb_r [fsc_pkg::NUM_PLANES];
  logic signed [31:0] nc_r [fsc_pkg::NUM_PLANES];
  logic signed [31:0] off_r [fsc_pkg::NUM_PLANES];

  logic signed [31:0] px_r, py_r, pz_r, margin_r;
  logic signed [63:0] v_r [6];
  logic signed [63:0] cr_r [3];
  logic signed [31:0] nr_r [3];
  logic [63:0] or_r;
  logic [6:0]  cnt_r;
  logic signed [63:0] prod_r, acc_r;
  logic        acc_en_r;
  fsc_pkg::acc_op_t acc_op_r;
  logic [63:0] sqv_r, sqr_r, sqb_r;
  logic [30:0] rem_r, q_r;
  logic        dbit_r, neg_r;
  logic        inside_r;

  logic signed [31:0] rx, ry, rz, opa, opb;
  logic signed [7:0]  sh;
  logic [63:0] mag0, shifted, sq_t_sum;
  logic signed [63:0] scaled, dv_src;
  logic [31:0] len32, t32;
  logic        zero_len;
  logic signed [33:0] fl;
  logic signed [34:0] neg_fl;
  logic signed [31:0] off_sat;
  logic signed [35:0] pdist;

  assign rx = cx_r[cmd.corner_sel];
  assign ry = cy_r[cmd.corner_sel];
  assign rz = cz_r[cmd.corner_sel];

  function automatic logic signed [31:0] pick(
    input fsc_pkg::opnd_t sel,
    input logic signed [63:0] v0, v1, v2, v3, v4, v5,
    input logic signed [31:0] n0, n1, n2, x, y, z, qa, qb, qc
  );
    case (sel)
      fsc_pkg::OPD_V0: return v0[31:0];
      fsc_pkg::OPD_V1: return v1[31:0];
      fsc_pkg::OPD_V2: return v2[31:0];
      fsc_pkg::OPD_V3: return v3[31:0];
      fsc_pkg::OPD_V4: return v4[31:0];
      fsc_pkg::OPD_V5: return v5[31:0];
      fsc_pkg::OPD_N0: return n0;
      fsc_pkg::OPD_N1: return n1;
      fsc_pkg::OPD_N2: return n2;
      fsc_pkg::OPD_PX: return x;
      fsc_pkg::OPD_PY: return y;
      fsc_pkg::OPD_PZ: return z;
      fsc_pkg::OPD_QA: return qa;
      fsc_pkg::OPD_QB: return qb;
      fsc_pkg::OPD_QC: return qc;
      default:         return '0;
    endcase
  endfunction

  assign opa = pick(cmd.opa, v_r[0], v_r[1], v_r[2], v_r[3], v_r[4], v_r[5],
                    nr_r[0], nr_r[1], nr_r[2], px_r, py_r, pz_r,
                    na_r[cmd.plane_idx], nb_r[cmd.plane_idx], nc_r[cmd.plane_idx]);
  assign opb = pick(cmd.opb, v_r[0], v_r[1], v_r[2], v_r[3], v_r[4], v_r[5],
                    nr_r[0], nr_r[1], nr_r[2], px_r, py_r, pz_r,
                    na_r[cmd.plane_idx], nb_r[cmd.plane_idx], nc_r[cmd.plane_idx]);

  // scale by 2^(30 - bit length), truncating toward zero
  assign sh      = 8'sd30 - $signed({1'b0, cnt_r});
  assign mag0    = fsc_pkg::mag64(v_r[0]);
  assign shifted = sh[7] ? (mag0 >> 6'(-sh)) : (mag0 << sh[5:0]);
  assign scaled  = v_r[0][63] ? -$signed(shifted) : $signed(shifted);

  assign sq_t_sum = sqr_r + sqb_r;
  assign len32    = sqr_r[31:0];
  assign zero_len = (sqr_r == 64'd0);
  assign t32      = {rem_r, dbit_r};

  always_comb begin
    case (cmd.div_idx)
      2'd0:    dv_src = v_r[0];
      2'd1:    dv_src = v_r[1];
      default: dv_src = v_r[2];
    endcase
  end

  assign fl     = acc_r[63:30];
  assign neg_fl = -35'(fl);
  assign off_sat = (neg_fl > 35'sd2147483647) ? 32'sh7fffffff :
                   (neg_fl < -35'sd2147483648) ? 32'sh80000000 : neg_fl[31:0];
  assign pdist  = 36'(fl) + 36'(off_r[cmd.plane_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fsc_pkg::NUM_CORNERS; i++) begin
        cx_r[i] <= '0;
        cy_r[i] <= '0;
        cz_r[i] <= '0;
      end
      for (int i = 0; i < fsc_pkg::NUM_PLANES; i++) begin
        na_r[i]  <= '0;
        nb_r[i]  <= '0;
        nc_r[i]  <= '0;
        off_r[i] <= '0;
      end
      acc_en_r <= 1'b0;
    end else begin
      if (cmd.accept && in_item.action == fsc_pkg::ACT_LOAD) begin
        cx_r[in_item.corner_index] <= in_item.pos_x;
        cy_r[in_item.corner_index] <= in_item.pos_y;
        cz_r[in_item.corner_index] <= in_item.pos_z;
      end
      if (cmd.plane_wr) begin
        na_r[cmd.plane_idx]  <= nr_r[0];
        nb_r[cmd.plane_idx]  <= nr_r[1];
        nc_r[cmd.plane_idx]  <= nr_r[2];
        off_r[cmd.plane_idx] <= off_sat;
      end
      acc_en_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r     <= in_item.pos_x;
      py_r     <= in_item.pos_y;
      pz_r     <= in_item.pos_z;
      margin_r <= in_item.margin;
      inside_r <= 1'b1;
    end
    case (cmd.crd)
      fsc_pkg::CRD_P: begin
        px_r <= rx;
        py_r <= ry;
        pz_r <= rz;
      end
      fsc_pkg::CRD_E0: begin
        v_r[0] <= 64'(px_r) - 64'(rx);
        v_r[1] <= 64'(py_r) - 64'(ry);
        v_r[2] <= 64'(pz_r) - 64'(rz);
      end
      fsc_pkg::CRD_E1: begin
        v_r[3] <= 64'(px_r) - 64'(rx);
        v_r[4] <= 64'(py_r) - 64'(ry);
        v_r[5] <= 64'(pz_r) - 64'(rz);
      end
      default: ;
    endcase
    case (cmd.nrm)
      fsc_pkg::NRM_LOAD: begin
        or_r  <= fsc_pkg::mag64(v_r[0]) | fsc_pkg::mag64(v_r[1]) | fsc_pkg::mag64(v_r[2]) |
                 fsc_pkg::mag64(v_r[3]) | fsc_pkg::mag64(v_r[4]) | fsc_pkg::mag64(v_r[5]);
        cnt_r <= '0;
      end
      fsc_pkg::NRM_COUNT: begin
        if (or_r != 64'd0) begin
          or_r  <= or_r >> 1;
          cnt_r <= cnt_r + 7'd1;
        end
      end
      fsc_pkg::NRM_SCALE: begin
        for (int i = 0; i < 5; i++) v_r[i] <= v_r[i+1];
        v_r[5] <= scaled;
      end
      default: ;
    endcase
    if (cmd.v_copy) begin
      for (int i = 0; i < 3; i++) begin
        v_r[i]   <= cr_r[i];
        v_r[i+3] <= '0;
      end
    end
    if (cmd.mul_en) begin
      prod_r   <= opa * opb;
      acc_op_r <= cmd.acc_op;
    end
    if (acc_en_r) begin
      case (acc_op_r)
        fsc_pkg::ACC_LOAD: acc_r <= prod_r;
        fsc_pkg::ACC_ADD:  acc_r <= acc_r + prod_r;
        fsc_pkg::ACC_SUB:  acc_r <= acc_r - prod_r;
        default:           acc_r <= acc_r;
      endcase
    end
    if (cmd.cr_wr) cr_r[cmd.cr_idx] <= acc_r;
    case (cmd.sq)
      fsc_pkg::SQ_LOAD: begin
        sqv_r <= acc_r;
        sqr_r <= '0;
        sqb_r <= 64'd1 << 62;
      end
      fsc_pkg::SQ_STEP: begin
        if (sqv_r >= sq_t_sum) begin
          sqv_r <= sqv_r - sq_t_sum;
          sqr_r <= (sqr_r >> 1) + sqb_r;
        end else begin
          sqr_r <= sqr_r >> 1;
        end
        sqb_r <= sqb_r >> 2;
      end
      default: ;
    endcase
    case (cmd.dv)
      fsc_pkg::DV_LOAD: begin
        rem_r  <= 31'(fsc_pkg::mag64(dv_src) >> 1);
        dbit_r <= dv_src[0];
        q_r    <= '0;
        neg_r  <= dv_src[63];
      end
      fsc_pkg::DV_STEP: begin
        if (t32 >= len32) begin
          rem_r <= 31'(t32 - len32);
          q_r   <= {q_r[29:0], 1'b1};
        end else begin
          rem_r <= t32[30:0];
          q_r   <= {q_r[29:0], 1'b0};
        end
        dbit_r <= 1'b0;
      end
      fsc_pkg::DV_STORE: begin
        nr_r[cmd.div_idx] <= zero_len ? 32'sd0 :
                             (neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r}));
      end
      default: ;
    endcase
    if (cmd.tst_check && pdist > 36'(margin_r)) inside_r <= 1'b0;
  end

  assign sts.or_zero    = (or_r == 64'd0);
  assign sts.in_frustum = inside_r;

endmodule

// ===== rtl/fsc_ctrl.sv =====
// fsc_ctrl: sequencer for corner loads, plane rebuilds and point tests
// depends on fsc_pkg; drives fsc_dp through cmd_t
module fsc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  fsc_pkg::in_item_t in_item,
  input  fsc_pkg::sts_t     sts,
  output fsc_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              out_valid,
  output logic              out_kind
);

  typedef enum logic [4:0] {
    S_IDLE, S_RD1, S_RD2, S_RD3, S_NLOAD, S_NCOUNT, S_NSCALE, S_CROSS, S_COPY,
    S_SQ, S_SQRT_LD, S_SQRT, S_DIV_LD, S_DIV, S_DIV_ST, S_DOT, S_TEST
  } state_t;

  state_t     state_r;
  logic [5:0] step_r;
  logic [2:0] plane_r;
  logic [1:0] j_r;
  logic       nphase_r, out_valid_r, out_kind_r;
  logic       accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    cmd            = '0;
    cmd.accept     = accept;
    cmd.plane_idx  = plane_r;
    cmd.crd        = fsc_pkg::CRD_NONE;
    cmd.nrm        = fsc_pkg::NRM_NONE;
    cmd.opa        = fsc_pkg::OPD_V0;
    cmd.opb        = fsc_pkg::OPD_V0;
    cmd.acc_op     = fsc_pkg::ACC_LOAD;
    cmd.sq         = fsc_pkg::SQ_NONE;
    cmd.dv         = fsc_pkg::DV_NONE;
    cmd.div_idx    = j_r;
    cmd.cr_idx     = step_r[3:2];
    case (state_r)
      S_RD1: begin
        cmd.crd        = fsc_pkg::CRD_P;
        cmd.corner_sel = fsc_pkg::tri_corner(plane_r, 2'd0);
      end
      S_RD2: begin
        cmd.crd        = fsc_pkg::CRD_E0;
        cmd.corner_sel = fsc_pkg::tri_corner(plane_r, 2'd1);
      end
      S_RD3: begin
        cmd.crd        = fsc_pkg::CRD_E1;
        cmd.corner_sel = fsc_pkg::tri_corner(plane_r, 2'd2);
      end
      S_NLOAD:  cmd.nrm = fsc_pkg::NRM_LOAD;
      S_NCOUNT: cmd.nrm = fsc_pkg::NRM_COUNT;
      S_NSCALE: cmd.nrm = fsc_pkg::NRM_SCALE;
      S_CROSS: begin
        cmd.mul_en = (step_r[1:0] == 2'd0) || (step_r[1:0] == 2'd1);
        cmd.acc_op = step_r[0] ? fsc_pkg::ACC_SUB : fsc_pkg::ACC_LOAD;
        cmd.cr_wr  = (step_r[1:0] == 2'd3);
        case ({step_r[3:2], step_r[0]})
          3'b000: begin cmd.opa = fsc_pkg::OPD_V1; cmd.opb = fsc_pkg::OPD_V5; end
          3'b001: begin cmd.opa = fsc_pkg::OPD_V2; cmd.opb = fsc_pkg::OPD_V4; end
          3'b010: begin cmd.opa = fsc_pkg::OPD_V2; cmd.opb = fsc_pkg::OPD_V3; end
          3'b011: begin cmd.opa = fsc_pkg::OPD_V0; cmd.opb = fsc_pkg::OPD_V5; end
          3'b100: begin cmd.opa = fsc_pkg::OPD_V0; cmd.opb = fsc_pkg::OPD_V4; end
          default: begin cmd.opa = fsc_pkg::OPD_V1; cmd.opb = fsc_pkg::OPD_V3; end
        endcase
      end
      S_COPY: cmd.v_copy = 1'b1;
      S_SQ: begin
        cmd.mul_en = (step_r < 6'd3);
        cmd.acc_op = (step_r == 6'd0) ? fsc_pkg::ACC_LOAD : fsc_pkg::ACC_ADD;
        case (step_r[1:0])
          2'd0:    begin cmd.opa = fsc_pkg::OPD_V0; cmd.opb = fsc_pkg::OPD_V0; end
          2'd1:    begin cmd.opa = fsc_pkg::OPD_V1; cmd.opb = fsc_pkg::OPD_V1; end
          default: begin cmd.opa = fsc_pkg::OPD_V2; cmd.opb = fsc_pkg::OPD_V2; end
        endcase
      end
      S_SQRT_LD: cmd.sq = fsc_pkg::SQ_LOAD;
      S_SQRT:    cmd.sq = fsc_pkg::SQ_STEP;
      S_DIV_LD:  cmd.dv = fsc_pkg::DV_LOAD;
      S_DIV:     cmd.dv = fsc_pkg::DV_STEP;
      S_DIV_ST:  cmd.dv = fsc_pkg::DV_STORE;
      S_DOT, S_TEST: begin
        cmd.mul_en    = (step_r < 6'd3);
        cmd.acc_op    = (step_r == 6'd0) ? fsc_pkg::ACC_LOAD : fsc_pkg::ACC_ADD;
        cmd.plane_wr  = (state_r == S_DOT) && (step_r == 6'd4);
        cmd.tst_check = (state_r == S_TEST) && (step_r == 6'd4);
        case (step_r[1:0])
          2'd0: begin
            cmd.opa = (state_r == S_DOT) ? fsc_pkg::OPD_N0 : fsc_pkg::OPD_QA;
            cmd.opb = fsc_pkg::OPD_PX;
          end
          2'd1: begin
            cmd.opa = (state_r == S_DOT) ? fsc_pkg::OPD_N1 : fsc_pkg::OPD_QB;
            cmd.opb = fsc_pkg::OPD_PY;
          end
          default: begin
            cmd.opa = (state_r == S_DOT) ? fsc_pkg::OPD_N2 : fsc_pkg::OPD_QC;
            cmd.opb = fsc_pkg::OPD_PZ;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      plane_r     <= '0;
      j_r         <= '0;
      nphase_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_kind_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_kind_r <= in_item.action;
            plane_r    <= '0;
            step_r     <= '0;
            if (in_item.action == fsc_pkg::ACT_TEST) begin
              state_r <= S_TEST;
            end else if (in_item.corner_index == fsc_pkg::LAST_CORNER) begin
              state_r <= S_RD1;
            end else begin
              out_valid_r <= 1'b1;
            end
          end
        end
        S_RD1: state_r <= S_RD2;
        S_RD2: state_r <= S_RD3;
        S_RD3: begin
          nphase_r <= 1'b0;
          state_r  <= S_NLOAD;
        end
        S_NLOAD: state_r <= S_NCOUNT;
        S_NCOUNT: begin
          if (sts.or_zero) begin
            step_r  <= '0;
            state_r <= S_NSCALE;
          end
        end
        S_NSCALE: begin
          step_r <= step_r + 6'd1;
          if (step_r == 6'd5) begin
            step_r  <= '0;
            state_r <= nphase_r ? S_SQ : S_CROSS;
          end
        end
        S_CROSS: begin
          step_r <= step_r + 6'd1;
          if (step_r == 6'd11) state_r <= S_COPY;
        end
        S_COPY: begin
          nphase_r <= 1'b1;
          state_r  <= S_NLOAD;
        end
        S_SQ: begin
          step_r <= step_r + 6'd1;
          if (step_r == 6'd3) state_r <= S_SQRT_LD;
        end
        S_SQRT_LD: begin
          step_r  <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          step_r <= step_r + 6'd1;
          if (step_r == 6'd31) begin
            j_r     <= '0;
            state_r <= S_DIV_LD;
          end
        end
        S_DIV_LD: begin
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          step_r <= step_r + 6'd1;
          if (step_r == 6'd30) state_r <= S_DIV_ST;
        end
        S_DIV_ST: begin
          step_r <= '0;
          if (j_r == 2'd2) begin
            state_r <= S_DOT;
          end else begin
            j_r     <= j_r + 2'd1;
            state_r <= S_DIV_LD;
          end
        end
        S_DOT, S_TEST: begin
          step_r <= step_r + 6'd1;
          if (step_r == 6'd4) begin
            step_r <= '0;
            if (plane_r == fsc_pkg::LAST_PLANE) begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              plane_r <= plane_r + 3'd1;
              state_r <= (state_r == S_DOT) ? S_RD1 : S_TEST;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;

  a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
    plane_r <= fsc_pkg::LAST_PLANE) else $error("plane counter out of range");

  a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.action == fsc_pkg::ACT_TEST |=> busy && !out_valid_r)
    else $error("test transaction not held busy");

  a_rebuild_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.action == fsc_pkg::ACT_LOAD &&
    in_item.corner_index == fsc_pkg::LAST_CORNER |=> busy)
    else $error("plane rebuild not started");

  a_load_reply: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.action == fsc_pkg::ACT_LOAD &&
    in_item.corner_index != fsc_pkg::LAST_CORNER |=> out_valid_r && !out_kind_r && !busy)
    else $error("corner load reply missing");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && $past(busy) |-> !busy)
    else $error("reply strobe while still busy");

endmodule

// ===== tb/sv/frustum_sphere_cull_checker.sv =====
// frustum_sphere_cull_checker: watches the command and reply channels of the cull block,
// predicts each reply from its own copy of corners and planes, and counts mismatches
// depends on fsc_pkg
module frustum_sphere_cull_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  fsc_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  fsc_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending_replies
);
  timeunit 1ns;
  timeprecision 1ps;
  import fsc_pkg::*;

  localparam int QSHIFT = 30;
  localparam logic [2:0] PLANE_CORNERS [NUM_PLANES][3] = '{
    '{3'd1, 3'd5, 3'd6}, '{3'd4, 3'd0, 3'd3}, '{3'd4, 3'd5, 3'd1},
    '{3'd3, 3'd2, 3'd6}, '{3'd5, 3'd4, 3'd7}, '{3'd0, 3'd1, 3'd2}
  };

  logic signed [31:0] cx [NUM_CORNERS];
  logic signed [31:0] cy [NUM_CORNERS];
  logic signed [31:0] cz [NUM_CORNERS];
  logic signed [31:0] pa [NUM_PLANES];
  logic signed [31:0] pb [NUM_PLANES];
  logic signed [31:0] pc [NUM_PLANES];
  logic signed [31:0] pd [NUM_PLANES];
  out_item_t expected_replies [$];

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic int width_of(longint unsigned m);
    int n;
    n = 0;
    while (m != 0) begin
      n++;
      m = m >> 1;
    end
    return n;
  endfunction

  function automatic longint shift_toward_zero(longint v, int sh);
    longint unsigned m;
    m = abs64(v);
    if (sh >= 0) m = m << sh;
    else m = m >> (-sh);
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic rebuild_plane(int k);
    int i1, i2, i3, sh;
    longint e [6];
    longint c [3];
    longint dot;
    longint unsigned m, sum, len, q;
    logic signed [31:0] n [3];
    i1 = PLANE_CORNERS[k][0];
    i2 = PLANE_CORNERS[k][1];
    i3 = PLANE_CORNERS[k][2];
    e[0] = longint'(cx[i1]) - longint'(cx[i2]);
    e[1] = longint'(cy[i1]) - longint'(cy[i2]);
    e[2] = longint'(cz[i1]) - longint'(cz[i2]);
    e[3] = longint'(cx[i1]) - longint'(cx[i3]);
    e[4] = longint'(cy[i1]) - longint'(cy[i3]);
    e[5] = longint'(cz[i1]) - longint'(cz[i3]);
    m = 0;
    for (int j = 0; j < 6; j++) if (abs64(e[j]) > m) m = abs64(e[j]);
    if (m != 0) begin
      sh = QSHIFT - width_of(m);
      for (int j = 0; j < 6; j++) e[j] = shift_toward_zero(e[j], sh);
    end
    c[0] = e[1] * e[5] - e[2] * e[4];
    c[1] = e[2] * e[3] - e[0] * e[5];
    c[2] = e[0] * e[4] - e[1] * e[3];
    m = 0;
    for (int j = 0; j < 3; j++) if (abs64(c[j]) > m) m = abs64(c[j]);
    if (m != 0) begin
      sh = QSHIFT - width_of(m);
      for (int j = 0; j < 3; j++) c[j] = shift_toward_zero(c[j], sh);
    end
    sum = 0;
    for (int j = 0; j < 3; j++) sum += abs64(c[j]) * abs64(c[j]);
    len = int_sqrt(sum);
    for (int j = 0; j < 3; j++) begin
      if (len == 0) begin
        n[j] = '0;
      end else begin
        q = (abs64(c[j]) << QSHIFT) / len;
        n[j] = c[j] < 0 ? 32'(-longint'(q)) : 32'(q);
      end
    end
    dot = longint'(n[0]) * cx[i1] + longint'(n[1]) * cy[i1] + longint'(n[2]) * cz[i1];
    dot = -(dot >>> QSHIFT);
    if (dot > 64'sd2147483647) dot = 64'sd2147483647;
    if (dot < -64'sd2147483648) dot = -64'sd2147483648;
    pa[k] = n[0];
    pb[k] = n[1];
    pc[k] = n[2];
    pd[k] = 32'(dot);
  endtask

  function automatic logic point_inside(in_item_t t);
    longint s, pdist;
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < NUM_PLANES; k++) begin
      s = longint'(pa[k]) * t.pos_x + longint'(pb[k]) * t.pos_y + longint'(pc[k]) * t.pos_z;
      pdist = (s >>> QSHIFT) + longint'(pd[k]);
      if (pdist > longint'(t.margin)) ok = 1'b0;
    end
    return ok;
  endfunction

  assign pending_replies = expected_replies.size();

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        cx[i] = '0;
        cy[i] = '0;
        cz[i] = '0;
      end
      for (int k = 0; k < NUM_PLANES; k++) begin
        pa[k] = '0;
        pb[k] = '0;
        pc[k] = '0;
        pd[k] = '0;
      end
      expected_replies.delete();
      fail_count = 0;
    end else begin
      if (start && !busy) begin
        want.reply_kind = in_data.action;
        if (in_data.action == ACT_LOAD) begin
          cx[in_data.corner_index] = in_data.pos_x;
          cy[in_data.corner_index] = in_data.pos_y;
          cz[in_data.corner_index] = in_data.pos_z;
          if (in_data.corner_index == LAST_CORNER)
            for (int k = 0; k < NUM_PLANES; k++) rebuild_plane(k);
          want.inside_res = 1'b0;
        end else begin
          want.inside_res = point_inside(in_data);
        end
        expected_replies.push_back(want);
      end
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected reply kind=%0b inside=%0b",
                     out_data.reply_kind, out_data.inside_res);
        end else begin
          want = expected_replies.pop_front();
          if (want.reply_kind !== out_data.reply_kind ||
              want.inside_res !== out_data.inside_res) begin
            fail_count++;
            if (fail_count <= 10)
              $display("reply mismatch: expected kind=%0b inside=%0b, got kind=%0b inside=%0b",
                       want.reply_kind, want.inside_res,
                       out_data.reply_kind, out_data.inside_res);
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/frustum_sphere_cull_top_tb.sv =====
// frustum_sphere_cull_top_tb: clock, reset and transaction stimulus for the cull block,
// with the checker beside it; prints the verdict
// depends on fsc_pkg, frustum_sphere_cull_top and frustum_sphere_cull_checker
module frustum_sphere_cull_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fsc_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;
  int        fail_count;
  int        pending_replies;
  longint    cycles = 0;
  int        gap_pct;

  frustum_sphere_cull_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  frustum_sphere_cull_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .fail_count(fail_count), .pending_replies(pending_replies)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // drives one transaction and returns at the edge that accepts it
  task automatic send(logic act, logic [2:0] idx, logic [31:0] x, logic [31:0] y,
                      logic [31:0] z, logic [31:0] mrg);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= '{action: act, corner_index: idx, pos_x: x, pos_y: y, pos_z: z, margin: mrg};
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [31:0] fixed_val(int ip);
    return (32'(ip) << 16) | 32'($urandom_range(65535));
  endfunction

  // loads a random frustum: near corners 0..3, far corners 4..7
  task automatic load_frustum(int hn, int hf, int zn, int zf, int ox, int oy);
    int sx [4] = '{-1, 1, 1, -1};
    int sy [4] = '{1, 1, -1, -1};
    for (int i = 0; i < 8; i++) begin
      if (i < 4) send(ACT_LOAD, 3'(i), fixed_val(ox + sx[i] * hn), fixed_val(oy + sy[i] * hn),
                      fixed_val(zn), 32'($urandom));
      else send(ACT_LOAD, 3'(i), fixed_val(ox + sx[i - 4] * hf),
                fixed_val(oy + sy[i - 4] * hf), fixed_val(zf), 32'($urandom));
    end
  endtask

  task automatic random_frustum();
    int hn, zn;
    hn = $urandom_range(1, 50);
    zn = $urandom_range(0, 50) - 25;
    load_frustum(hn, hn + $urandom_range(0, 200), zn, zn + $urandom_range(1, 400),
                 $urandom_range(0, 100) - 50, $urandom_range(0, 100) - 50);
  endtask

  task automatic test_point(int span);
    logic [31:0] mrg;
    case ($urandom_range(3))
      0:       mrg = '0;
      1:       mrg = fixed_val($urandom_range(0, 20) - 10);
      2:       mrg = 32'($urandom_range(65535)) - 32'd32768;
      default: mrg = 32'($urandom);
    endcase
    send(ACT_TEST, 3'($urandom), fixed_val($urandom_range(0, 2 * span) - span),
         fixed_val($urandom_range(0, 2 * span) - span),
         fixed_val($urandom_range(0, 2 * span + 100) - 50), mrg);
  endtask

  initial begin
    int sent;
    gap_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // planes still zero: passes only with non-negative margin
    send(ACT_TEST, 3'd0, 32'h7fffffff, 32'h80000000, 32'h0, 32'h0);
    send(ACT_TEST, 3'd7, 32'h0, 32'h0, 32'h0, 32'hffffffff);
    send(ACT_TEST, 3'd3, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h7fffffff);
    // all corners coincident: degenerate planes
    send(ACT_LOAD, 3'd7, 32'h0, 32'h0, 32'h0, 32'h0);
    send(ACT_TEST, 3'd0, 32'h10000, 32'h0, 32'h0, 32'h0);
    send(ACT_TEST, 3'd0, 32'h10000, 32'h0, 32'h0, 32'h80000000);
    // well-formed frustum, inside and outside
    load_frustum(2, 20, 1, 100, 0, 0);
    send(ACT_TEST, 3'd0, 32'h0, 32'h0, 32'h00320000, 32'h0);
    send(ACT_TEST, 3'd0, 32'h01000000, 32'h0, 32'h00320000, 32'h0);
    send(ACT_TEST, 3'd0, 32'h01000000, 32'h0, 32'h00320000, 32'h7fffffff);
    send(ACT_TEST, 3'd0, 32'h0, 32'h0, 32'h80000000, 32'h0);
    // extreme corners: saturated offsets
    send(ACT_LOAD, 3'd0, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0);
    send(ACT_LOAD, 3'd1, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h0);
    send(ACT_LOAD, 3'd5, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h0);
    send(ACT_LOAD, 3'd7, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'hffffffff);
    send(ACT_TEST, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    send(ACT_TEST, 3'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);

    // pause until every reply is in
    start <= 1'b0;
    while (pending_replies != 0) @(posedge clk);

    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 7 : (ph == 1) ? 47 : 0;
      while (sent < 220 * (ph + 1)) begin
        case ($urandom_range(9))
          0: begin
            random_frustum();
            sent += 8;
          end
          1: begin
            send(ACT_LOAD, 3'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                 32'($urandom));
            sent++;
          end
          2: begin
            send(ACT_TEST, 3'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                 32'($urandom));
            sent++;
          end
          default: begin
            test_point($urandom_range(0, 1) ? 30 : 300);
            sent++;
          end
        endcase
      end
    end
    start <= 1'b0;

    while (pending_replies != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_replies == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
